@@ rtl/bsb_pkg.sv @@
// Shared types, constants and tap tables for the 5x5 B-spline blur.
package bsb_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int ROW_W      = 16;
    localparam int OUT_COL_W  = 12;
    localparam int FW_W       = 13;
    localparam int TAPS       = 5;
    localparam int NUM_OFFS   = 3;   // output positions per axis: center-2 .. center
    localparam int LB_ROWS    = 4;
    localparam int WGT_W      = 4;
    localparam int VSUM_W     = SAMPLE_W + 4;   // column weights total 16
    localparam int HSUM_W     = SAMPLE_W + 8;   // full kernel totals 256
    localparam int ROUND_BITS = 8;

    // result tdata layout: filtered | out_row | out_col | zero pad
    localparam int OUT_ROW_LSB = SAMPLE_W;
    localparam int OUT_COL_LSB = OUT_ROW_LSB + ROW_W;
    localparam int M_TDATA_W   = 48;
    localparam int M_PAD_W     = M_TDATA_W - OUT_COL_LSB - OUT_COL_W;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 1'd1;
    localparam int RESET_DIM = 64;

    typedef logic [SAMPLE_W-1:0]                      sample_t;
    typedef logic [ROW_W-1:0]                         row_t;
    typedef logic [VSUM_W-1:0]                        vsum_t;
    typedef logic [LB_ROWS-1:0][SAMPLE_W-1:0]         slot_data_t;
    typedef logic [TAPS-1:0][WGT_W-1:0]               tap_row_t;
    typedef logic [TAPS-1:0][VSUM_W-1:0]              vsum_row_t;
    typedef logic [NUM_OFFS-1:0][TAPS-1:0][VSUM_W-1:0] vsum_win_t;

    // Position info for one request: which of the 3x3 candidate outputs exist.
    typedef struct packed {
        logic       row_end;   // last row of the frame
        logic       col_end;   // last column of the row
        logic       col_zero;  // first column: window refills
        logic [1:0] d_first;   // first valid row offset (row = R-2+d)
        logic [1:0] e_first;   // first valid column offset (col = x-2+e)
    } pos_ctl_t;

    // Binomial weights with the far side folded onto the edge tap.
    // Offset 0: centered two taps back; 1: one back; 2: at the newest tap.
    function automatic tap_row_t tap_row(input logic [1:0] off);
        tap_row_t w;
        case (off)
            2'd0:    w = {4'd1, 4'd4, 4'd6, 4'd4, 4'd1};
            2'd1:    w = {4'd5, 4'd6, 4'd4, 4'd1, 4'd0};
            2'd2:    w = {4'd11, 4'd4, 4'd1, 4'd0, 4'd0};
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

@@ rtl/bspline_5x5_blur_clamped.sv @@
// Top level of the streaming 5x5 B-spline blur with clamp-to-edge borders.
// s_ channel: one 16-bit unsigned pixel per request, raster order, for a
//   frame_width x frame_height frame (registers 0 and 1 of the write port).
//   A register write restarts the frame at (0,0); write only while idle.
// m_ channel: filtered pixel with its row/column. Pixel (r,c) comes out once
//   input (min(r+2,H-1), min(c+2,W-1)) is in. An input yields zero or one
//   result, up to three at the right edge or on the last row, nine for the
//   last input of the frame, in raster order. tlast marks the last result of
//   one input, tuser the final result (H-1,W-1) of the frame.
// Timing: one input per clock while each yields at most one result and m_tready
//   is high. An accepted input passes the sample and line-buffer read register,
//   the vertical sum window and the horizontal sum into the output register. An
//   input with several results holds the result sequencer until its last is emitted.
// Reset (aresetn low, synchronous): empties the pipeline, sets 64x64 and
//   restarts at (0,0). The line buffer keeps its contents; each entry is
//   rewritten in a frame before it is read, so there is no clearing pass.
// Stall: while m_tready is low the result waits in the output register, the
//   two stages behind it still fill, then s_tready goes low.
module bspline_5x5_blur_clamped #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata: [15:0] sample
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bsb_pkg::SAMPLE_W-1:0]   s_tdata,
    // m_tdata: [15:0] filtered, [31:16] out_row, [43:32] out_col, [47:44] zero
    // m_tlast: run_last; m_tuser: [0] frame_done
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bsb_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tlast,
    output logic                           m_tuser,
    // register write port: 0 frame_width, 1 frame_height
    input  logic                           cfg_wr_en,
    input  logic [bsb_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [bsb_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import bsb_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int RESET_W = (RESET_DIM > MAX_WIDTH) ? MAX_WIDTH : RESET_DIM;
    localparam logic [COL_W-1:0] RESET_COL_LAST = COL_W'(RESET_W - 1);
    localparam row_t RESET_ROW_LAST = ROW_W'(RESET_DIM - 1);

    // frame geometry, stored as last index
    logic [COL_W-1:0] col_last_reg;
    row_t             row_last_reg;
    logic [COL_W-1:0] width_last;
    row_t             height_last;

    // position of the next input
    logic [COL_W-1:0] col_count_reg;
    row_t             row_count_reg;

    // stage 1: accepted sample, waiting on its line-buffer read
    logic             s1_valid_reg;
    sample_t          s1_sample_reg;
    row_t             s1_row_reg;
    logic [COL_W-1:0] s1_col_reg;
    pos_ctl_t         s1_ctl_reg;
    pos_ctl_t         ctl_next;

    logic             in_accept;
    logic             s2_free;
    logic             load;
    slot_data_t       rd_data;
    vsum_win_t        win;
    logic [FW_W-1:0]  fw;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = !s1_valid_reg || s2_free;
    assign load      = s1_valid_reg && s2_free;

    // zero means one; width uses bits 12:0, saturates at the line-buffer size
    assign fw = cfg_wr_data[FW_W-1:0];
    always_comb begin
        if (fw == '0) begin
            width_last = '0;
        end else if (32'(fw) > 32'(MAX_WIDTH)) begin
            width_last = COL_W'(MAX_WIDTH - 1);
        end else begin
            width_last = COL_W'(fw - FW_W'(1));
        end
        if (cfg_wr_data == '0) begin
            height_last = '0;
        end else begin
            height_last = ROW_W'(cfg_wr_data - CFG_DATA_W'(1));
        end
    end

    always_comb begin
        ctl_next.row_end  = (row_count_reg == row_last_reg);
        ctl_next.col_end  = (col_count_reg == col_last_reg);
        ctl_next.col_zero = (col_count_reg == '0);
        if (row_count_reg == '0) begin
            ctl_next.d_first = 2'd2;
        end else if (row_count_reg == ROW_W'(1)) begin
            ctl_next.d_first = 2'd1;
        end else begin
            ctl_next.d_first = 2'd0;
        end
        if (col_count_reg == '0) begin
            ctl_next.e_first = 2'd2;
        end else if (col_count_reg == COL_W'(1)) begin
            ctl_next.e_first = 2'd1;
        end else begin
            ctl_next.e_first = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_last_reg  <= RESET_COL_LAST;
            row_last_reg  <= RESET_ROW_LAST;
            col_count_reg <= '0;
            row_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_FRAME_WIDTH:  col_last_reg <= width_last;
                    REG_FRAME_HEIGHT: row_last_reg <= height_last;
                    default: ;
                endcase
                col_count_reg <= '0;
                row_count_reg <= '0;
            end else if (in_accept) begin
                if (ctl_next.col_end) begin
                    col_count_reg <= '0;
                    row_count_reg <= ctl_next.row_end ? '0 : row_count_reg + ROW_W'(1);
                end else begin
                    col_count_reg <= col_count_reg + COL_W'(1);
                end
            end
            if (in_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (load) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_sample_reg <= s_tdata;
            s1_row_reg    <= row_count_reg;
            s1_col_reg    <= col_count_reg;
            s1_ctl_reg    <= ctl_next;
        end
    end

    bsb_line_buf #(
        .MAX_WIDTH (MAX_WIDTH),
        .ADDR_W    (COL_W)
    ) u_line_buf (
        .aclk    (aclk),
        .acc_en  (in_accept),
        .addr    (col_count_reg),
        .wr_slot (row_count_reg[1:0]),
        .wr_data (s_tdata),
        .rd_data (rd_data)
    );

    bsb_vfilt u_vfilt (
        .aclk     (aclk),
        .load     (load),
        .row      (s1_row_reg),
        .sample   (s1_sample_reg),
        .col_zero (s1_ctl_reg.col_zero),
        .rd_data  (rd_data),
        .win      (win)
    );

    bsb_hfilt #(
        .COL_W (COL_W)
    ) u_hfilt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .row_in   (s1_row_reg),
        .col_in   (s1_col_reg),
        .ctl_in   (s1_ctl_reg),
        .win      (win),
        .s2_free  (s2_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

@@ rtl/bsb_line_buf.sv @@
// Four-row line buffer: one bank per row slot, read-first, registered read.
module bsb_line_buf #(
    parameter int MAX_WIDTH = 4096,
    parameter int ADDR_W    = 12
) (
    input  logic                aclk,
    input  logic                acc_en,
    input  logic [ADDR_W-1:0]   addr,
    input  logic [1:0]          wr_slot,
    input  bsb_pkg::sample_t    wr_data,
    output bsb_pkg::slot_data_t rd_data
);
    import bsb_pkg::*;

    for (genvar b = 0; b < LB_ROWS; b++) begin : g_bank
        sample_t mem [MAX_WIDTH];
        sample_t rd_reg;

        always_ff @(posedge aclk) begin
            if (acc_en) begin
                rd_reg <= mem[addr];
                if (wr_slot == 2'(b)) begin
                    mem[addr] <= wr_data;
                end
            end
        end

        assign rd_data[b] = rd_reg;
    end

endmodule

@@ rtl/bsb_vfilt.sv @@
// Column assembly, vertical 5-tap sums and the 5-column sum window.
module bsb_vfilt (
    input  logic                aclk,
    input  logic                load,
    input  bsb_pkg::row_t       row,
    input  bsb_pkg::sample_t    sample,
    input  logic                col_zero,
    input  bsb_pkg::slot_data_t rd_data,
    output bsb_pkg::vsum_win_t  win
);
    import bsb_pkg::*;

    sample_t [TAPS-1:0]     column;
    vsum_t   [NUM_OFFS-1:0] vsum_new;
    vsum_win_t              win_reg;
    vsum_win_t              win_next;
    tap_row_t               wrow;

    // column[j] holds row R-4+j, clamped to row 0 above the frame
    always_comb begin
        for (int j = 0; j < TAPS - 1; j++) begin
            if (row == '0) begin
                column[j] = sample;
            end else if (row < ROW_W'(TAPS - 1 - j)) begin
                column[j] = rd_data[0];
            end else begin
                column[j] = rd_data[2'(row[1:0] + 2'(j))];
            end
        end
        column[TAPS-1] = sample;
    end

    always_comb begin
        for (int d = 0; d < NUM_OFFS; d++) begin
            wrow = tap_row(2'(d));
            vsum_new[d] = '0;
            for (int j = 0; j < TAPS; j++) begin
                vsum_new[d] = vsum_new[d] + VSUM_W'(column[j]) * VSUM_W'(wrow[j]);
            end
        end
    end

    always_comb begin
        for (int d = 0; d < NUM_OFFS; d++) begin
            for (int i = 0; i < TAPS - 1; i++) begin
                win_next[d][i] = col_zero ? vsum_new[d] : win_reg[d][i+1];
            end
            win_next[d][TAPS-1] = vsum_new[d];
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            win_reg <= win_next;
        end
    end

    assign win = win_reg;

endmodule

@@ rtl/bsb_hfilt.sv @@
// Result sequencer: walks up to 3x3 outputs per request, horizontal sum, output register.
module bsb_hfilt #(
    parameter int COL_W = 12
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load,
    input  bsb_pkg::row_t                 row_in,
    input  logic [COL_W-1:0]              col_in,
    input  bsb_pkg::pos_ctl_t             ctl_in,
    input  bsb_pkg::vsum_win_t            win,
    output logic                          s2_free,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bsb_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast,
    output logic                          m_tuser
);
    import bsb_pkg::*;

    logic               s2_valid_reg;
    row_t               row_reg;
    logic [COL_W-1:0]   col_reg;
    pos_ctl_t           ctl_reg;
    logic [1:0]         d_reg;
    logic [1:0]         e_reg;

    logic               m_valid_reg;
    sample_t            filt_reg;
    row_t               orow_reg;
    logic [OUT_COL_W-1:0] ocol_reg;
    logic               last_reg;
    logic               done_reg;

    logic [1:0]         d_end;
    logic [1:0]         e_end;
    logic               has_out;
    logic               out_free;
    logic               emit;
    logic               last_e;
    logic               item_last;
    vsum_row_t          vrow;
    tap_row_t           wrow;
    logic [HSUM_W-1:0]  hsum;
    logic [HSUM_W-1:0]  hsum_rnd;
    sample_t            filt_next;
    row_t               orow_next;
    logic [COL_W-1:0]   ocol_next;

    assign d_end   = ctl_reg.row_end ? 2'd2 : 2'd0;
    assign e_end   = ctl_reg.col_end ? 2'd2 : 2'd0;
    assign has_out = (ctl_reg.d_first == 2'd0 || ctl_reg.row_end) &&
                     (ctl_reg.e_first == 2'd0 || ctl_reg.col_end);

    assign out_free  = !m_valid_reg || m_tready;
    assign emit      = s2_valid_reg && has_out && out_free;
    assign last_e    = (e_reg == e_end);
    assign item_last = last_e && (d_reg == d_end);
    assign s2_free   = !s2_valid_reg || !has_out || (out_free && item_last);

    always_comb begin
        case (d_reg)
            2'd0:    vrow = win[0];
            2'd1:    vrow = win[1];
            2'd2:    vrow = win[2];
            default: vrow = '0;
        endcase
    end

    always_comb begin
        wrow = tap_row(e_reg);
        hsum = '0;
        for (int i = 0; i < TAPS; i++) begin
            hsum = hsum + HSUM_W'(vrow[i]) * HSUM_W'(wrow[i]);
        end
        hsum_rnd  = hsum + HSUM_W'(1 << (ROUND_BITS - 1));
        filt_next = SAMPLE_W'(hsum_rnd >> ROUND_BITS);
        orow_next = row_reg + ROW_W'(d_reg) - ROW_W'(2);
        ocol_next = col_reg + COL_W'(e_reg) - COL_W'(2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (load) begin
                s2_valid_reg <= 1'b1;
            end else if (s2_free) begin
                s2_valid_reg <= 1'b0;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            row_reg <= row_in;
            col_reg <= col_in;
            ctl_reg <= ctl_in;
            d_reg   <= ctl_in.d_first;
            e_reg   <= ctl_in.e_first;
        end else if (emit) begin
            if (last_e) begin
                e_reg <= ctl_reg.e_first;
                d_reg <= d_reg + 2'd1;
            end else begin
                e_reg <= e_reg + 2'd1;
            end
        end
        if (emit) begin
            filt_reg <= filt_next;
            orow_reg <= orow_next;
            ocol_reg <= OUT_COL_W'(ocol_next);
            last_reg <= item_last;
            done_reg <= item_last && ctl_reg.row_end && ctl_reg.col_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {M_PAD_W'(0), ocol_reg, orow_reg, filt_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = done_reg;

endmodule

@@ rtl/bsb_checker.sv @@
// Port-level checks on the blur's result channel, bound to the top level.
module bsb_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [bsb_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast,
    input logic                          m_tuser
);
    import bsb_pkg::*;

    logic after_frame_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            after_frame_reg <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            after_frame_reg <= m_tuser;
        end
    end

    // no result survives reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tlast) && $stable(m_tuser))
        else $error("result changed while stalled");

    // end of frame is always the last result of its input
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame_done without run_last");

    // next frame starts at pixel (0,0)
    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && after_frame_reg |->
            m_tdata[OUT_COL_LSB+OUT_COL_W-1:OUT_ROW_LSB] == '0)
        else $error("first result after frame end is not (0,0)");

endmodule

bind bspline_5x5_blur_clamped bsb_checker u_bsb_checker (.*);
